/* design/ptd_pkg.sv */
// Shared types, widths and codes for the priority timer dispatcher.
// No dependencies; every other design file refers to this package by scoped names.
package ptd_pkg;

    localparam int MAX_HANDLERS = 16;
    localparam int MAX_RESULTS  = 16;

    localparam int AW     = $clog2(MAX_HANDLERS);
    localparam int CW     = $clog2(MAX_HANDLERS + 1);
    localparam int RW     = $clog2(MAX_RESULTS + 1);
    localparam int CMD_W  = 2;
    localparam int PRIO_W = 8;
    localparam int ID_W   = 4;
    localparam int TIME_W = 48;
    localparam int SUM_W  = TIME_W + 1;
    localparam int WAIT_W = 37;

    localparam longint unsigned ONE_DAY_US = 64'd24 * 64'd60 * 64'd60 * 64'd1000000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_SET      = 2'd1,
        CMD_TIMEOUT  = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] act_time;
        logic [ID_W-1:0]   ident;
    } entry_t;

    typedef struct packed {
        logic         re;
        logic [AW-1:0] raddr;
        logic         we;
        logic [AW-1:0] waddr;
        entry_t       wdata;
    } ram_req_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PRIO_W-1:0] priority_req;
        logic [ID_W-1:0]   handler_ref;
        logic [TIME_W-1:0] activation_us;
        logic [TIME_W-1:0] now_us;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [WAIT_W-1:0] wait_us;
        status_t           status;
        logic              last;
    } res_t;

endpackage

/* design/priority_timer_dispatcher_core.sv */
// Top level of the priority timer dispatcher: handler table RAM, sequencer
// and output register. Depends on ptd_pkg, ptd_entry_ram, ptd_sequencer, ptd_out_stage.
//
// Request words (cmd, priority_req, handler_ref, activation_us, now_us) enter on
// req_valid/req_stall; result words (handler_id, wait_us, status, last) leave on
// rsp_valid/rsp_stall. Each request gives one result word, except dispatch with due
// handlers: one word per due handler in priority order, last set on the final one.
// One request is worked on at a time: req_stall is high from acceptance until the
// final result word has entered the output register, which may still hold a word
// while the next request is taken. The handler table sits in a RAM with one read
// and one write port; scans read one entry per cycle; dispatch waits for output space.
// For n stored handlers, add walks back from the tail, moving lower-priority entries
// down (at most n compared), then writes the new entry; set scans to the matching
// handler; timeout scans every entry; dispatch scans to the end or the result cap.
// Add on a full table and set, timeout or dispatch on an empty one go straight to the
// result word. req_stall falls as the final word enters the output register and
// rsp_valid rises, so the next request can be taken in the cycle after. When the
// receiver stalls, the output register holds its word and the sequencer waits before
// each further word. Reset empties the table at once (the handler count goes to zero);
// no clearing pass is needed, since only entries below the count are ever read.
module priority_timer_dispatcher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  priority_req,
    input  logic [3:0]  handler_ref,
    input  logic [47:0] activation_us,
    input  logic [47:0] now_us,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [3:0]  handler_id,
    output logic [36:0] wait_us,
    output logic [1:0]  status,
    output logic        last
);

    ptd_pkg::req_t     req;
    ptd_pkg::ram_req_t ram;
    ptd_pkg::entry_t   rdata;
    ptd_pkg::res_t     push_res;
    ptd_pkg::res_t     rsp_res;
    logic              push;
    logic              space;
    logic              busy;

    assign req = '{cmd: cmd, priority_req: priority_req, handler_ref: handler_ref,
                   activation_us: activation_us, now_us: now_us};

    assign req_stall = busy;

    ptd_entry_ram u_ram (
        .clk   (clk),
        .ram   (ram),
        .rdata (rdata)
    );

    ptd_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (busy),
        .ram       (ram),
        .rdata     (rdata),
        .space     (space),
        .push      (push),
        .push_res  (push_res)
    );

    ptd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .rsp_stall (rsp_stall),
        .space     (space),
        .rsp_valid (rsp_valid),
        .rsp_res   (rsp_res)
    );

    assign handler_id = rsp_res.id;
    assign wait_us    = rsp_res.wait_us;
    assign status     = rsp_res.status;
    assign last       = rsp_res.last;

endmodule

/* design/ptd_entry_ram.sv */
// Handler table storage: one write port and one registered read port.
// Depends on ptd_pkg for the entry type and address width.
module ptd_entry_ram (
    input  logic              clk,
    input  ptd_pkg::ram_req_t ram,
    output ptd_pkg::entry_t   rdata
);

    ptd_pkg::entry_t mem [ptd_pkg::MAX_HANDLERS];
    ptd_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ram.we)
        begin
            mem[ram.waddr] <= ram.wdata;
        end
        if (ram.re)
        begin
            rdata_reg <= mem[ram.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/ptd_out_stage.sv */
// Output register for result words; frees the sequencer from the receiver.
// Depends on ptd_pkg for the result type.
module ptd_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ptd_pkg::res_t push_res,
    input  logic          rsp_stall,
    output logic          space,
    output logic          rsp_valid,
    output ptd_pkg::res_t rsp_res
);

    logic          valid_reg;
    logic          valid_next;
    ptd_pkg::res_t res_reg;

    // A new word may enter when the register is empty or is drained this cycle.
    assign space = !valid_reg || !rsp_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_res   = res_reg;

endmodule

/* design/ptd_sequencer.sv */
// Command sequencer: walks the handler table through the RAM read port,
// shifts entries on insertion and produces result words. Depends on ptd_pkg.
module ptd_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  ptd_pkg::req_t     req,
    output logic              busy,
    output ptd_pkg::ram_req_t ram,
    input  ptd_pkg::entry_t   rdata,
    input  logic              space,
    output logic              push,
    output ptd_pkg::res_t     push_res
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_ADD_SHIFT = 9'b000000010,
        S_ADD_PLACE = 9'b000000100,
        S_SET_SCAN  = 9'b000001000,
        S_TO_SCAN   = 9'b000010000,
        S_TO_FIN    = 9'b000100000,
        S_DISP_SCAN = 9'b001000000,
        S_EMIT      = 9'b010000000,
        S_SPARE     = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ptd_pkg::CW-1:0]          count_reg, count_next;
    logic [ptd_pkg::AW-1:0]          ptr_reg, ptr_next;
    logic [ptd_pkg::AW-1:0]          place_reg, place_next;
    logic [ptd_pkg::SUM_W-1:0]       min_time_reg, min_time_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [ptd_pkg::ID_W-1:0]        pend_id_reg, pend_id_next;
    logic [ptd_pkg::RW-1:0]          due_cnt_reg, due_cnt_next;
    ptd_pkg::res_t                   res_reg, res_next;

    logic [ptd_pkg::PRIO_W-1:0]      prio_reg;
    logic [ptd_pkg::ID_W-1:0]        ref_reg;
    logic [ptd_pkg::TIME_W-1:0]      act_reg;
    logic [ptd_pkg::TIME_W-1:0]      now_reg;

    logic                            accept;
    logic                            at_end;
    logic                            due;
    logic                            cap_hit;
    logic [ptd_pkg::SUM_W-1:0]       cand;
    logic [ptd_pkg::SUM_W:0]         diff;
    logic [ptd_pkg::ID_W-1:0]        final_id;
    logic                            final_valid;

    assign busy   = (state_reg != S_IDLE);
    assign accept = req_valid && !busy;

    // The word in rdata belongs to table position ptr_reg.
    assign at_end  = ((ptd_pkg::CW'(ptr_reg) + ptd_pkg::CW'(1)) == count_reg);
    assign due     = ({1'b0, rdata.act_time} < {1'b0, now_reg});
    assign cap_hit = due && ((due_cnt_reg + ptd_pkg::RW'(1)) == ptd_pkg::RW'(ptd_pkg::MAX_RESULTS));
    assign cand    = ({1'b0, rdata.act_time} < min_time_reg) ? {1'b0, rdata.act_time}
                                                              : min_time_reg;
    assign diff    = {1'b0, min_time_reg} - {2'b00, now_reg};
    assign final_id    = due ? rdata.ident : pend_id_reg;
    assign final_valid = due || pend_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        place_next      = place_reg;
        min_time_next   = min_time_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        due_cnt_next    = due_cnt_reg;
        res_next        = res_reg;
        ram             = '0;
        push            = 1'b0;
        push_res        = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (ptd_pkg::cmd_t'(req.cmd))
                        ptd_pkg::CMD_ADD:
                        begin
                            if (count_reg == ptd_pkg::CW'(ptd_pkg::MAX_HANDLERS))
                            begin
                                res_next   = '{id: '0, wait_us: '0,
                                               status: ptd_pkg::ST_FULL, last: 1'b1};
                                state_next = S_EMIT;
                            end
                            else if (count_reg == '0)
                            begin
                                place_next = '0;
                                state_next = S_ADD_PLACE;
                            end
                            else
                            begin
                                // Walk backward from the tail, moving lower priorities down.
                                ram.re     = 1'b1;
                                ram.raddr  = ptd_pkg::AW'(count_reg - ptd_pkg::CW'(1));
                                ptr_next   = ptd_pkg::AW'(count_reg - ptd_pkg::CW'(1));
                                state_next = S_ADD_SHIFT;
                            end
                        end
                        ptd_pkg::CMD_SET:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = '{id: req.handler_ref, wait_us: '0,
                                               status: ptd_pkg::ST_UNKNOWN, last: 1'b1};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                ram.re     = 1'b1;
                                ram.raddr  = '0;
                                ptr_next   = '0;
                                state_next = S_SET_SCAN;
                            end
                        end
                        ptd_pkg::CMD_TIMEOUT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = '{id: '0, wait_us: '0,
                                               status: ptd_pkg::ST_EMPTY, last: 1'b1};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                ram.re        = 1'b1;
                                ram.raddr     = '0;
                                ptr_next      = '0;
                                min_time_next = {1'b0, req.now_us}
                                                + ptd_pkg::SUM_W'(ptd_pkg::ONE_DAY_US);
                                state_next    = S_TO_SCAN;
                            end
                        end
                        ptd_pkg::CMD_DISPATCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = '{id: '0, wait_us: '0,
                                               status: ptd_pkg::ST_EMPTY, last: 1'b1};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                ram.re          = 1'b1;
                                ram.raddr       = '0;
                                ptr_next        = '0;
                                pend_valid_next = 1'b0;
                                due_cnt_next    = '0;
                                state_next      = S_DISP_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD_SHIFT:
            begin
                if (rdata.prio < prio_reg)
                begin
                    ram.we    = 1'b1;
                    ram.waddr = ptr_reg + ptd_pkg::AW'(1);
                    ram.wdata = rdata;
                    if (ptr_reg == '0)
                    begin
                        place_next = '0;
                        state_next = S_ADD_PLACE;
                    end
                    else
                    begin
                        ram.re    = 1'b1;
                        ram.raddr = ptr_reg - ptd_pkg::AW'(1);
                        ptr_next  = ptr_reg - ptd_pkg::AW'(1);
                    end
                end
                else
                begin
                    place_next = ptr_reg + ptd_pkg::AW'(1);
                    state_next = S_ADD_PLACE;
                end
            end

            S_ADD_PLACE:
            begin
                ram.we     = 1'b1;
                ram.waddr  = place_reg;
                ram.wdata  = '{prio: prio_reg, act_time: now_reg,
                               ident: ptd_pkg::ID_W'(count_reg)};
                count_next = count_reg + ptd_pkg::CW'(1);
                res_next   = '{id: ptd_pkg::ID_W'(count_reg), wait_us: '0,
                               status: ptd_pkg::ST_OK, last: 1'b1};
                state_next = S_EMIT;
            end

            S_SET_SCAN:
            begin
                if (rdata.ident == ref_reg)
                begin
                    ram.we     = 1'b1;
                    ram.waddr  = ptr_reg;
                    ram.wdata  = '{prio: rdata.prio, act_time: act_reg, ident: rdata.ident};
                    res_next   = '{id: ref_reg, wait_us: '0,
                                   status: ptd_pkg::ST_OK, last: 1'b1};
                    state_next = S_EMIT;
                end
                else if (at_end)
                begin
                    res_next   = '{id: ref_reg, wait_us: '0,
                                   status: ptd_pkg::ST_UNKNOWN, last: 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    ram.re    = 1'b1;
                    ram.raddr = ptr_reg + ptd_pkg::AW'(1);
                    ptr_next  = ptr_reg + ptd_pkg::AW'(1);
                end
            end

            S_TO_SCAN:
            begin
                min_time_next = cand;
                if (at_end)
                begin
                    state_next = S_TO_FIN;
                end
                else
                begin
                    ram.re    = 1'b1;
                    ram.raddr = ptr_reg + ptd_pkg::AW'(1);
                    ptr_next  = ptr_reg + ptd_pkg::AW'(1);
                end
            end

            S_TO_FIN:
            begin
                // A negative difference means the earliest activation is already past.
                res_next   = '{id: '0,
                               wait_us: diff[ptd_pkg::SUM_W] ? '0 : ptd_pkg::WAIT_W'(diff),
                               status: ptd_pkg::ST_OK, last: 1'b1};
                state_next = S_EMIT;
            end

            S_DISP_SCAN:
            begin
                // One due id is held back until we know whether it is the final one.
                if (!(due && pend_valid_reg && !space))
                begin
                    if (due)
                    begin
                        if (pend_valid_reg)
                        begin
                            push     = 1'b1;
                            push_res = '{id: pend_id_reg, wait_us: '0,
                                         status: ptd_pkg::ST_OK, last: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rdata.ident;
                        due_cnt_next    = due_cnt_reg + ptd_pkg::RW'(1);
                    end
                    if (at_end || cap_hit)
                    begin
                        if (final_valid)
                        begin
                            res_next = '{id: final_id, wait_us: '0,
                                         status: ptd_pkg::ST_OK, last: 1'b1};
                        end
                        else
                        begin
                            res_next = '{id: '0, wait_us: '0,
                                         status: ptd_pkg::ST_EMPTY, last: 1'b1};
                        end
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ram.re    = 1'b1;
                        ram.raddr = ptr_reg + ptd_pkg::AW'(1);
                        ptr_next  = ptr_reg + ptd_pkg::AW'(1);
                    end
                end
            end

            S_EMIT:
            begin
                if (space)
                begin
                    push       = 1'b1;
                    push_res   = res_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            due_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            due_cnt_reg    <= due_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        place_reg    <= place_next;
        min_time_reg <= min_time_next;
        pend_id_reg  <= pend_id_next;
        res_reg      <= res_next;
        if (accept)
        begin
            prio_reg <= req.priority_req;
            ref_reg  <= req.handler_ref;
            act_reg  <= req.activation_us;
            now_reg  <= req.now_us;
        end
    end

endmodule

/* tb/sv/tb_priority_timer_dispatcher_core.sv */
// Self-checking testbench for priority_timer_dispatcher_core: random traffic on both
// handshakes is checked word by word against a predictor of the sorted handler table.
// Depends on ptd_pkg and the RTL of the core only.
module tb_priority_timer_dispatcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ptd_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX   = '1;
    localparam int                HOLD_AT    = 45;
    localparam int                HOLD_LEN   = 300;
    localparam int                TAIL_WAIT  = 40;

    typedef struct {
        cmd_t              cmd;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   target;
        logic [TIME_W-1:0] act;
        logic [TIME_W-1:0] now;
        bit                drain_first;
    } sched_cmd_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [1:0]        cmd = '0;
    logic [7:0]        priority_req = '0;
    logic [3:0]        handler_ref = '0;
    logic [47:0]       activation_us = '0;
    logic [47:0]       now_us = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic [3:0]        handler_id;
    logic [36:0]       wait_us;
    logic [1:0]        status;
    logic              last;

    priority_timer_dispatcher_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .cmd           (cmd),
        .priority_req  (priority_req),
        .handler_ref   (handler_ref),
        .activation_us (activation_us),
        .now_us        (now_us),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .handler_id    (handler_id),
        .wait_us       (wait_us),
        .status        (status),
        .last          (last)
    );

    // Mirror of the handler table, kept in priority order.
    logic [PRIO_W-1:0] tab_prio [MAX_HANDLERS];
    logic [TIME_W-1:0] tab_time [MAX_HANDLERS];
    logic [ID_W-1:0]   tab_id   [MAX_HANDLERS];
    int                n_handlers = 0;

    sched_cmd_t  outgoing_cmds [$];
    res_t        predicted_words [$];
    sched_cmd_t  cur_cmd = '{CMD_ADD, 8'd0, 4'd0, 48'd0, 48'd0, 1'b0};
    bit          have_item = 1'b0;
    bit          quiet = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int          hold_left = 0;
    bit          hold_fired = 1'b0;
    int          cmds_accepted = 0;
    int          words_checked = 0;
    int          full_answers = 0;
    int          longest_burst = 0;
    int          errors = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #12_000_000;
        $display("tb_priority_timer_dispatcher_core: FAIL");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none at all during quiet stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void expect_word(logic [ID_W-1:0] id, logic [WAIT_W-1:0] w,
                                        status_t st, logic lst);
        res_t r;
        r.id      = id;
        r.wait_us = w;
        r.status  = st;
        r.last    = lst;
        predicted_words.push_back(r);
    endfunction

    // Updates the table mirror for one accepted command and queues its result words.
    function automatic void apply_command(sched_cmd_t c);
        int                i;
        int                pos;
        bit                hit;
        longint unsigned   horizon;
        logic [ID_W-1:0]   due_ids [$];
        case (c.cmd)
            CMD_ADD: begin
                if (n_handlers >= MAX_HANDLERS) begin
                    expect_word('0, '0, ST_FULL, 1'b1);
                    full_answers++;
                end else begin
                    // A new entry goes behind every entry of equal or higher priority.
                    pos = 0;
                    while (pos < n_handlers && tab_prio[pos] >= c.prio)
                        pos++;
                    for (i = n_handlers; i > pos; i--) begin
                        tab_prio[i] = tab_prio[i-1];
                        tab_time[i] = tab_time[i-1];
                        tab_id[i]   = tab_id[i-1];
                    end
                    tab_prio[pos] = c.prio;
                    tab_time[pos] = c.now;
                    tab_id[pos]   = ID_W'(n_handlers);
                    expect_word(ID_W'(n_handlers), '0, ST_OK, 1'b1);
                    n_handlers++;
                end
            end
            CMD_SET: begin
                hit = 1'b0;
                for (i = 0; i < n_handlers && !hit; i++) begin
                    if (tab_id[i] == c.target) begin
                        tab_time[i] = c.act;
                        hit = 1'b1;
                    end
                end
                if (hit)
                    expect_word(c.target, '0, ST_OK, 1'b1);
                else
                    expect_word(c.target, '0, ST_UNKNOWN, 1'b1);
            end
            CMD_TIMEOUT: begin
                if (n_handlers == 0) begin
                    expect_word('0, '0, ST_EMPTY, 1'b1);
                end else begin
                    horizon = 64'(c.now) + ONE_DAY_US;
                    for (i = 0; i < n_handlers; i++)
                        if (64'(tab_time[i]) < horizon)
                            horizon = 64'(tab_time[i]);
                    if (horizon < 64'(c.now))
                        horizon = 64'(c.now);
                    expect_word('0, WAIT_W'(horizon - 64'(c.now)), ST_OK, 1'b1);
                end
            end
            default: begin
                for (i = 0; i < n_handlers && due_ids.size() < MAX_RESULTS; i++)
                    if (tab_time[i] < c.now)
                        due_ids.push_back(tab_id[i]);
                if (due_ids.size() == 0) begin
                    expect_word('0, '0, ST_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < due_ids.size(); i++)
                        expect_word(due_ids[i], '0, ST_OK, i == due_ids.size() - 1);
                    if (due_ids.size() > longest_burst)
                        longest_burst = due_ids.size();
                end
            end
        endcase
    endfunction

    function automatic void queue_cmd(cmd_t c, logic [PRIO_W-1:0] p, logic [ID_W-1:0] t,
                                      logic [TIME_W-1:0] a, logic [TIME_W-1:0] nw,
                                      bit drain);
        sched_cmd_t s;
        s.cmd         = c;
        s.prio        = p;
        s.target      = t;
        s.act         = a;
        s.now         = nw;
        s.drain_first = drain;
        outgoing_cmds.push_back(s);
    endfunction

    // Activation times mostly near the running clock, some a day out, some anywhere.
    function automatic logic [TIME_W-1:0] pick_time(logic [TIME_W-1:0] base);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return base - 48'd1000 + TIME_W'($urandom_range(0, 3000));
        if (r < 75)
            return base + TIME_W'(ONE_DAY_US) - 48'd500 + TIME_W'($urandom_range(0, 1000));
        if (r < 85)
            return TIME_W'({$urandom(), $urandom()});
        if (r < 92)
            return '0;
        return TIME_MAX;
    endfunction

    // Word sender: valid is decided without looking at req_stall and held until taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            have_item = 1'b0;
            gap_left  = 0;
        end else begin
            if (req_valid && !req_stall) begin
                apply_command(cur_cmd);
                cmds_accepted++;
                have_item = 1'b0;
                gap_left  = pick_gap();
                if ($urandom_range(0, 39) == 0)
                    quiet = !quiet;
            end
            if (!have_item) begin
                if (gap_left > 0)
                    gap_left--;
                else if (outgoing_cmds.size() != 0 &&
                         !(outgoing_cmds[0].drain_first && predicted_words.size() != 0)) begin
                    cur_cmd   = outgoing_cmds.pop_front();
                    have_item = 1'b1;
                end
            end
            req_valid     <= have_item;
            cmd           <= cur_cmd.cmd;
            priority_req  <= cur_cmd.prio;
            handler_ref   <= cur_cmd.target;
            activation_us <= cur_cmd.act;
            now_us        <= cur_cmd.now;
        end
    end

    // One long receiver hold-off, so the core backs up and stalls its input.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (!hold_fired && cmds_accepted >= HOLD_AT) begin
            hold_left  <= HOLD_LEN;
            hold_fired <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result receiver and checker.
    always @(posedge clk or negedge rst_n) begin : rsp_side
        res_t want;
        if (!rst_n) begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                if (predicted_words.size() == 0) begin
                    $error("result word with nothing outstanding: handler_id %0d status %0d",
                           handler_id, status);
                    errors++;
                end else begin
                    want = predicted_words.pop_front();
                    words_checked++;
                    if (handler_id !== want.id) begin
                        $error("handler_id: expected %0d, got %0d", want.id, handler_id);
                        errors++;
                    end
                    if (wait_us !== want.wait_us) begin
                        $error("wait_us: expected %0d, got %0d", want.wait_us, wait_us);
                        errors++;
                    end
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                rsp_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_stall <= 1'b1;
            end else begin
                rsp_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        int                k;
        int unsigned       sel;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] nw;
        logic [PRIO_W-1:0] p;

        // Empty table, the one-day cap, equal priorities, unknown ids, nothing due.
        queue_cmd(CMD_TIMEOUT,  8'd0,   4'd0,  48'd0,    48'd500,         1'b0);
        queue_cmd(CMD_DISPATCH, 8'd0,   4'd0,  48'd0,    TIME_MAX,        1'b0);
        queue_cmd(CMD_SET,      8'd0,   4'd9,  48'd1234, 48'd0,           1'b0);
        queue_cmd(CMD_ADD,      8'd7,   4'd0,  48'd0,    TIME_MAX,        1'b0);
        queue_cmd(CMD_TIMEOUT,  8'd0,   4'd0,  48'd0,    48'd0,           1'b0);
        queue_cmd(CMD_TIMEOUT,  8'd0,   4'd0,  48'd0,    TIME_MAX,        1'b0);
        queue_cmd(CMD_TIMEOUT,  8'd0,   4'd0,  48'd0,    TIME_MAX - 48'd1, 1'b0);
        queue_cmd(CMD_ADD,      8'd255, 4'd0,  48'd0,    48'd0,           1'b0);
        queue_cmd(CMD_ADD,      8'd0,   4'd0,  48'd0,    48'd100,         1'b0);
        queue_cmd(CMD_ADD,      8'd7,   4'd0,  48'd0,    48'd50,          1'b0);
        queue_cmd(CMD_SET,      8'd0,   4'd3,  48'd10,   48'd0,           1'b0);
        queue_cmd(CMD_SET,      8'd0,   4'd12, TIME_MAX, 48'd0,           1'b0);
        queue_cmd(CMD_DISPATCH, 8'd0,   4'd0,  48'd0,    48'd0,           1'b0);
        queue_cmd(CMD_DISPATCH, 8'd0,   4'd0,  48'd0,    TIME_MAX,        1'b0);
        queue_cmd(CMD_TIMEOUT,  8'd0,   4'd0,  48'd0,    48'd20,          1'b0);
        queue_cmd(CMD_DISPATCH, 8'd0,   4'd0,  48'd0,    48'd11,          1'b0);

        // Random traffic around a clock that moves forward; late on it jumps near the top.
        base = TIME_W'({$urandom_range(0, 255), $urandom()});
        for (k = 0; k < 195; k++) begin
            base = base + TIME_W'($urandom_range(0, 400));
            if (k == 165)
                base = TIME_MAX - 48'd20000;
            nw  = base + TIME_W'($urandom_range(0, 50));
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                p = PRIO_W'($urandom_range(0, 255));
                if ($urandom_range(0, 9) == 0)
                    p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                queue_cmd(CMD_ADD, p, ID_W'($urandom_range(0, 15)), pick_time(base), nw,
                          k == 80 || k == 140);
            end else if (sel < 45) begin
                queue_cmd(CMD_SET, PRIO_W'($urandom_range(0, 255)),
                          ID_W'($urandom_range(0, 15)),
                          pick_time(base), nw, k == 80 || k == 140);
            end else if (sel < 62) begin
                queue_cmd(CMD_TIMEOUT, PRIO_W'($urandom_range(0, 255)),
                          ID_W'($urandom_range(0, 15)),
                          pick_time(base), nw, k == 80 || k == 140);
            end else begin
                queue_cmd(CMD_DISPATCH, PRIO_W'($urandom_range(0, 255)),
                          ID_W'($urandom_range(0, 15)),
                          pick_time(base), nw, k == 80 || k == 140);
            end
        end

        while (outgoing_cmds.size() != 0 || have_item)
            @(posedge clk);
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Run covered %0d commands and %0d result words: %0d table-full answers,",
                 cmds_accepted, words_checked, full_answers);
        $display("dispatch bursts of up to %0d words, and a %0d-cycle receiver hold-off.",
                 longest_burst, HOLD_LEN);
        if (errors == 0)
            $display("tb_priority_timer_dispatcher_core: PASS");
        else
            $display("tb_priority_timer_dispatcher_core: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
design/ptd_pkg.sv
design/ptd_entry_ram.sv
design/ptd_out_stage.sv
design/ptd_sequencer.sv
design/priority_timer_dispatcher_core.sv
tb/sv/tb_priority_timer_dispatcher_core.sv
